// ===== rtl/shared_baud_generator_allocator_defines.svh =====
// Assertion macros used by the file that carries checks.
`ifndef SHARED_BAUD_GENERATOR_ALLOCATOR_DEFINES_SVH
`define SHARED_BAUD_GENERATOR_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbga check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbga check failed");

`endif

// ===== rtl/sbga_pkg.sv =====
`default_nettype none

package sbga_pkg;

    localparam int NUM_GENERATORS = 4;
    localparam int NUM_CHANNELS   = 6;

    localparam int CLK_W    = 28;
    localparam int CHAN_W   = 3;
    localparam int BAUD_W   = 22;
    localparam int STATUS_W = 2;
    localparam int GEN_W    = 2;
    localparam int WORD_W   = 17;

    localparam int GEN_IDX_W = (NUM_GENERATORS > 1) ? $clog2(NUM_GENERATORS) : 1;
    localparam int USERS_W   = $clog2(NUM_CHANNELS + 1);

    localparam int PRESCALE_SHIFT = 4;
    localparam int NUM_W          = CLK_W - PRESCALE_SHIFT + 1;
    localparam int REM_W          = BAUD_W + 1;
    localparam int STEP_CNT_W     = $clog2(NUM_W);
    localparam int DIV_W          = 13;
    localparam int DIVM1_W        = DIV_W - 1;
    localparam int PAD_W          = WORD_W - DIVM1_W - 2;

    localparam logic [CLK_W-1:0] CLK_RESET     = CLK_W'(50000000);
    localparam logic [DIV_W-1:0] DIV_LIMIT     = DIV_W'(4096);
    localparam logic [NUM_W:0]   PRESCALE_HALF = (NUM_W + 1)'(8);

    localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_GEN  = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
        logic make_word;
        logic commit;
    } sbga_cmd_t;

    typedef struct packed {
        logic div_last;
    } sbga_sts_t;

endpackage

`default_nettype wire

// ===== rtl/sbga_if.sv =====
`default_nettype none

interface sbga_req_if import sbga_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] channel;
    logic [BAUD_W-1:0] baud_rate;

    modport source (output valid, output channel, output baud_rate, input ready);
    modport sink (input valid, input channel, input baud_rate, output ready);
endinterface

interface sbga_rsp_if import sbga_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [GEN_W-1:0]    generator;
    logic [WORD_W-1:0]   generator_word;

    modport source (output valid, output status, output generator,
                    output generator_word, input ready);
    modport sink (input valid, input status, input generator,
                  input generator_word, output ready);
endinterface

interface sbga_cfg_if import sbga_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CLK_W-1:0] bus_clock_hz;

    modport source (output valid, output bus_clock_hz, input ready);
    modport sink (input valid, input bus_clock_hz, output ready);
endinterface

`default_nettype wire

// ===== rtl/sbga_dp.sv =====
`default_nettype none

module sbga_dp
    import sbga_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sbga_cmd_t           cmd,
    output sbga_sts_t                sts,
    input  wire logic                cfg_we,
    input  wire logic [CLK_W-1:0]    cfg_clock,
    input  wire logic [CHAN_W-1:0]   req_channel,
    input  wire logic [BAUD_W-1:0]   req_baud,
    output logic      [STATUS_W-1:0] out_status,
    output logic      [GEN_W-1:0]    out_generator,
    output logic      [WORD_W-1:0]   out_word
);

    logic [CLK_W-1:0]      bus_clock_reg;
    logic [WORD_W-1:0]     gen_word_reg [NUM_GENERATORS];
    logic [USERS_W-1:0]    gen_users_reg [NUM_GENERATORS];
    logic                  bound_reg [NUM_CHANNELS];
    logic [GEN_IDX_W-1:0]  binding_reg [NUM_CHANNELS];
    logic [STEP_CNT_W-1:0] cnt_reg;

    logic [NUM_W-1:0]      q_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [BAUD_W-1:0]     baud_reg;
    logic [CHAN_W-1:0]     chan_reg;
    logic [WORD_W-1:0]     word_reg;
    logic                  bad_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [GEN_W-1:0]      out_generator_reg;
    logic [WORD_W-1:0]     out_word_reg;

    logic [REM_W-1:0]      rem_sh;
    logic                  ge;
    logic [REM_W-1:0]      rem_next;
    logic [NUM_W-1:0]      q_next;
    logic [NUM_W-1:0]      num_next;

    logic [NUM_W:0]        rounded;
    logic [NUM_W-PRESCALE_SHIFT:0] pre_q;
    logic                  big;
    logic [DIV_W-1:0]      div_val;
    logic [DIVM1_W-1:0]    div_m1;
    logic [WORD_W-1:0]     word_next;
    logic                  bad_next;

    logic                  chan_ok;
    logic                  had_old;
    logic [GEN_IDX_W-1:0]  old_gen;
    logic [USERS_W-1:0]    old_users;
    logic                  match_any;
    logic [GEN_IDX_W-1:0]  match_idx;
    logic                  free_any;
    logic [GEN_IDX_W-1:0]  free_idx;
    logic                  owned;
    logic                  found;
    logic [GEN_IDX_W-1:0]  pick;
    logic                  granted;
    logic [STATUS_W-1:0]   status_next;
    logic [USERS_W-1:0]    users_next [NUM_GENERATORS];

    assign sts.div_last = (cnt_reg == STEP_CNT_W'(NUM_W - 1));

    assign num_next = NUM_W'(bus_clock_reg >> PRESCALE_SHIFT) + NUM_W'(req_baud >> 1);
    assign rem_sh   = {rem_reg[REM_W-2:0], q_reg[NUM_W-1]};
    assign ge       = (rem_sh >= {1'b0, baud_reg});
    assign rem_next = ge ? (rem_sh - {1'b0, baud_reg}) : rem_sh;
    assign q_next   = {q_reg[NUM_W-2:0], ge};

    always_comb
    begin
        rounded = {1'b0, q_reg} + PRESCALE_HALF;
        pre_q   = rounded[NUM_W:PRESCALE_SHIFT];
        big     = (q_reg > NUM_W'(DIV_LIMIT));
        if (!big)
        begin
            div_val = q_reg[DIV_W-1:0];
        end
        else if (pre_q > (NUM_W - PRESCALE_SHIFT + 1)'(DIV_LIMIT))
        begin
            div_val = DIV_LIMIT;
        end
        else
        begin
            div_val = pre_q[DIV_W-1:0];
        end
        div_m1    = DIVM1_W'(div_val - DIV_W'(1));
        word_next = {1'b1, {PAD_W{1'b0}}, div_m1, big};
        bad_next  = (baud_reg == '0) || (q_reg == '0);
    end

    always_comb
    begin
        chan_ok   = ({1'b0, chan_reg} < (CHAN_W + 1)'(NUM_CHANNELS));
        had_old   = 1'b0;
        old_gen   = '0;
        old_users = '0;
        match_any = 1'b0;
        match_idx = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (CHAN_W'(c) == chan_reg)
            begin
                had_old = bound_reg[c];
                old_gen = binding_reg[c];
            end
        end
        for (int g = NUM_GENERATORS - 1; g >= 0; g--)
        begin
            if (GEN_IDX_W'(g) == old_gen)
            begin
                old_users = gen_users_reg[g];
            end
            if (gen_word_reg[g] == word_reg)
            begin
                match_any = 1'b1;
                match_idx = GEN_IDX_W'(g);
            end
            if (gen_users_reg[g] == '0)
            begin
                free_any = 1'b1;
                free_idx = GEN_IDX_W'(g);
            end
        end
        owned = had_old && (old_users == USERS_W'(1));
        found = match_any || owned || free_any;
        if (match_any)
        begin
            pick = match_idx;
        end
        else if (owned)
        begin
            pick = old_gen;
        end
        else
        begin
            pick = free_idx;
        end
        granted = !bad_reg && chan_ok && found;
        if (bad_reg)
        begin
            status_next = ST_BAD;
        end
        else if (granted)
        begin
            status_next = ST_GRANTED;
        end
        else
        begin
            status_next = ST_NO_GEN;
        end
        for (int g = 0; g < NUM_GENERATORS; g++)
        begin
            users_next[g] = gen_users_reg[g];
            if (had_old && (GEN_IDX_W'(g) == old_gen) && (gen_users_reg[g] != '0))
            begin
                users_next[g] = users_next[g] - USERS_W'(1);
            end
            if (GEN_IDX_W'(g) == pick)
            begin
                users_next[g] = users_next[g] + USERS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_clock_reg <= CLK_RESET;
            cnt_reg       <= '0;
            for (int g = 0; g < NUM_GENERATORS; g++)
            begin
                gen_word_reg[g]  <= '0;
                gen_users_reg[g] <= '0;
            end
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                bound_reg[c]   <= 1'b0;
                binding_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                bus_clock_reg <= cfg_clock;
            end
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + STEP_CNT_W'(1);
            end
            if (cmd.commit && granted)
            begin
                for (int g = 0; g < NUM_GENERATORS; g++)
                begin
                    gen_users_reg[g] <= users_next[g];
                    if (GEN_IDX_W'(g) == pick)
                    begin
                        gen_word_reg[g] <= word_reg;
                    end
                end
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (CHAN_W'(c) == chan_reg)
                    begin
                        bound_reg[c]   <= 1'b1;
                        binding_reg[c] <= pick;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg    <= num_next;
            rem_reg  <= '0;
            baud_reg <= req_baud;
            chan_reg <= req_channel;
        end
        else if (cmd.step)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
        if (cmd.make_word)
        begin
            word_reg <= word_next;
            bad_reg  <= bad_next;
        end
        if (cmd.commit)
        begin
            out_status_reg    <= status_next;
            out_generator_reg <= granted ? GEN_W'(pick) : '0;
            out_word_reg      <= granted ? word_reg : '0;
        end
    end

    assign out_status    = out_status_reg;
    assign out_generator = out_generator_reg;
    assign out_word      = out_word_reg;

endmodule

`default_nettype wire

// ===== rtl/sbga_ctrl.sv =====
`default_nettype none

module sbga_ctrl
    import sbga_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output sbga_cmd_t      cmd,
    input  wire sbga_sts_t sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_WORD  = 2'd2;
    localparam logic [1:0] S_ALLOC = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_WORD;
                end
            end
            S_WORD:
            begin
                cmd.make_word = 1'b1;
                state_next    = S_ALLOC;
            end
            S_ALLOC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/shared_baud_generator_allocator.sv =====
// An accepted item passes the divide, word-build and allocate states before its
// result is valid; the 25-step restoring divider that forms the divisor yields
// one quotient bit per cycle. A new item is accepted only in the idle state.
// The result waits in an output register, so a new item is taken meanwhile.
// Reset (rst_n, asynchronous, active low) clears all generators and bindings
// and sets the bus clock register to 50000000; no clearing pass is needed.
`default_nettype none
`include "shared_baud_generator_allocator_defines.svh"

module shared_baud_generator_allocator
    import sbga_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    sbga_cfg_if.sink    cfg,
    sbga_req_if.sink    req,
    sbga_rsp_if.source  rsp
);

    sbga_cmd_t cmd;
    sbga_sts_t sts;

    assign cfg.ready = 1'b1;

    sbga_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sbga_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg.valid),
        .cfg_clock     (cfg.bus_clock_hz),
        .req_channel   (req.channel),
        .req_baud      (req.baud_rate),
        .out_status    (rsp.status),
        .out_generator (rsp.generator),
        .out_word      (rsp.generator_word)
    );

    `SBGA_ASSERT_NEXT(a_one_item, clk, rst_n, req.valid && req.ready, !req.ready)
    `SBGA_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, rsp.valid)
    `SBGA_ASSERT_IMP(a_grant_enabled, clk, rst_n, rsp.valid && rsp.status == ST_GRANTED, rsp.generator_word[WORD_W-1])
    `SBGA_ASSERT_IMP(a_reject_clear, clk, rst_n, rsp.valid && rsp.status != ST_GRANTED, rsp.generator == '0 && rsp.generator_word == '0)

endmodule

`default_nettype wire

// ===== verif/sbga_grant_checker.sv =====
`timescale 1ns / 100ps

module sbga_grant_checker
    import sbga_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sbga_cfg_if  cfg,
    sbga_req_if  req,
    sbga_rsp_if  rsp,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GEN_W-1:0]    generator;
        logic [WORD_W-1:0]   word;
    } grant_t;

    grant_t             grant_queue[$];
    grant_t             want;
    int                 errors;
    logic [CLK_W-1:0]   bus_clock;
    logic [WORD_W-1:0]  gen_word [NUM_GENERATORS];
    logic [USERS_W-1:0] gen_users [NUM_GENERATORS];
    logic               chan_bound [NUM_CHANNELS];
    logic [GEN_W-1:0]   chan_gen [NUM_CHANNELS];

    function automatic logic [WORD_W-1:0] baud_word(input logic [CLK_W-1:0] hz,
                                                    input logic [BAUD_W-1:0] baud);
        longint unsigned num;
        longint unsigned den;
        longint unsigned div;
        logic            pre;
        pre = 1'b0;
        num = hz;
        den = baud;
        if (den == 0)
            return '0;
        div = ((num >> PRESCALE_SHIFT) + (den >> 1)) / den;
        if (div == 0)
            return '0;
        if (div > DIV_LIMIT)
        begin
            pre = 1'b1;
            div = (div + PRESCALE_HALF) >> PRESCALE_SHIFT;
            if (div > DIV_LIMIT)
                div = DIV_LIMIT;
        end
        return {1'b1, PAD_W'(0), DIVM1_W'(div - 1), pre};
    endfunction

    task automatic predict_grant(input logic [CHAN_W-1:0] chan, input logic [BAUD_W-1:0] baud);
        grant_t            res;
        logic [WORD_W-1:0] word;
        logic              found;
        int                pick;
        int                old;
        res = '0;
        found = 1'b0;
        pick = 0;
        old = 0;
        word = baud_word(bus_clock, baud);
        if (word == '0)
            res.status = ST_BAD;
        else if (chan >= NUM_CHANNELS)
            res.status = ST_NO_GEN;
        else
        begin
            if (chan_bound[chan])
                old = chan_gen[chan];
            for (int g = 0; g < NUM_GENERATORS; g++)
            begin
                if (!found && gen_word[g] == word)
                begin
                    found = 1'b1;
                    pick = g;
                end
            end
            if (!found && chan_bound[chan] && gen_users[old] == 1)
            begin
                found = 1'b1;
                pick = old;
            end
            for (int g = 0; g < NUM_GENERATORS; g++)
            begin
                if (!found && gen_users[g] == 0)
                begin
                    found = 1'b1;
                    pick = g;
                end
            end
            if (!found)
                res.status = ST_NO_GEN;
            else
            begin
                if (chan_bound[chan] && gen_users[old] > 0)
                    gen_users[old] = gen_users[old] - 1'b1;
                gen_users[pick] = gen_users[pick] + 1'b1;
                gen_word[pick] = word;
                chan_bound[chan] = 1'b1;
                chan_gen[chan] = GEN_W'(pick);
                res.status = ST_GRANTED;
                res.generator = GEN_W'(pick);
                res.word = word;
            end
        end
        grant_queue.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grant_queue.delete();
            errors = 0;
            bus_clock = CLK_RESET;
            for (int g = 0; g < NUM_GENERATORS; g++)
            begin
                gen_word[g] = '0;
                gen_users[g] = '0;
            end
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                chan_bound[c] = 1'b0;
                chan_gen[c] = '0;
            end
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                bus_clock = cfg.bus_clock_hz;
            if (rsp.valid && rsp.ready)
            begin
                if (grant_queue.size() == 0)
                begin
                    $error("unexpected result item: status %0d generator %0d word 0x%05h",
                           rsp.status, rsp.generator, rsp.generator_word);
                    errors++;
                end
                else
                begin
                    want = grant_queue.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.generator !== want.generator)
                    begin
                        $error("generator: expected %0d, actual %0d",
                               want.generator, rsp.generator);
                        errors++;
                    end
                    if (rsp.generator_word !== want.word)
                    begin
                        $error("generator_word: expected 0x%05h, actual 0x%05h",
                               want.word, rsp.generator_word);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_grant(req.channel, req.baud_rate);
            fail_count <= errors;
            pending <= grant_queue.size();
        end
    end

endmodule

// ===== verif/tb_shared_baud_generator_allocator.sv =====
`timescale 1ns / 100ps

module tb_shared_baud_generator_allocator
    import sbga_pkg::*;
;

    localparam int SETTLE_CYCLES = 30;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 280;
    localparam int MAX_BAUD      = 4000000;
    localparam int CLOCK_MAX     = 200000000;
    localparam int unsigned STD_BAUD [10] = '{300, 1200, 2400, 4800, 9600, 19200,
                                              38400, 57600, 115200, 230400};
    localparam int IDLE_PCT  [4] = '{0, 75, 0, 27};
    localparam int STALL_PCT [4] = '{0, 0, 75, 27};

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          pending;
    int          idle_pct;
    int          stall_pct;
    int          items_sent;
    int          clock_writes;
    int unsigned hz_now;
    int unsigned hz_next;
    int          phase_items;
    logic [CHAN_W-1:0] rand_chan;
    logic [BAUD_W-1:0] rand_baud;

    sbga_cfg_if cfg_ch ();
    sbga_req_if req_ch ();
    sbga_rsp_if rsp_ch ();

    shared_baud_generator_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sbga_grant_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        rsp_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic send_request(input logic [CHAN_W-1:0] chan, input logic [BAUD_W-1:0] baud);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.channel = chan;
        req_ch.baud_rate = baud;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_bus_clock(input int unsigned hz);
        cfg_ch.valid = 1'b1;
        cfg_ch.bus_clock_hz = CLK_W'(hz);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        hz_now = hz;
        clock_writes++;
    endtask

    task automatic pick_request(output logic [CHAN_W-1:0] chan, output logic [BAUD_W-1:0] baud);
        int          roll;
        int unsigned near_top;
        if ($urandom_range(99) < 90)
            chan = CHAN_W'($urandom_range(NUM_CHANNELS - 1));
        else
            chan = CHAN_W'($urandom_range(7));
        near_top = (hz_now >> 3) + 1;
        if (near_top > MAX_BAUD)
            near_top = MAX_BAUD;
        roll = $urandom_range(99);
        if (roll < 4)
            baud = '0;
        else if (roll < 55)
            baud = BAUD_W'(STD_BAUD[$urandom_range(9)]);
        else if (roll < 70)
            baud = BAUD_W'($urandom_range(1, 800));
        else if (roll < 85)
            baud = BAUD_W'($urandom_range(1, near_top));
        else if (roll < 98)
            baud = BAUD_W'($urandom_range(1, MAX_BAUD));
        else
            baud = BAUD_W'($urandom);
    endtask

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.bus_clock_hz = '0;
        req_ch.valid = 1'b0;
        req_ch.channel = '0;
        req_ch.baud_rate = '0;
        rsp_ch.ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        clock_writes = 0;
        hz_now = 50000000;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Allocation, sharing, exhaustion and rounding at the reset bus clock.
        send_request(0, 0);
        send_request(6, 9600);
        send_request(7, MAX_BAUD);
        send_request(0, 9600);
        send_request(1, 9600);
        send_request(2, 19200);
        send_request(3, 38400);
        send_request(4, 57600);
        send_request(5, 115200);
        send_request(0, 115200);
        send_request(2, 115200);
        send_request(2, 9600);
        send_request(3, 115200);
        send_request(1, 763);
        send_request(5, 762);
        send_request(4, 1);
        send_request(3, MAX_BAUD);
        send_request(0, '1);
        wait_idle();

        // A slow bus clock gives small divisors, and one that rounds to zero.
        write_bus_clock(1000);
        send_request(0, 200);
        send_request(1, 31);
        send_request(2, 1);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: hz_next = CLOCK_MAX;
                1: hz_next = 1;
                2: hz_next = 16;
                3: hz_next = 1843200;
                4: hz_next = 50000000;
                5: hz_next = 14745600;
                default: hz_next = $urandom_range(1, CLOCK_MAX);
            endcase
            write_bus_clock(hz_next);
            idle_pct = IDLE_PCT[p % 4];
            stall_pct = STALL_PCT[p % 4];
            phase_items = (hz_next == 1) ? 30 : PHASE_ITEMS;
            for (int i = 0; i < phase_items; i++)
            begin
                pick_request(rand_chan, rand_baud);
                send_request(rand_chan, rand_baud);
            end
            wait_idle();
            idle_pct = 0;
            stall_pct = 0;
        end

        $display("Summary: %0d requests checked over %0d bus clock settings,", items_sent,
                 clock_writes + 1);
        $display("         with idle and stall phases on both channels.");
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
